// ----- hw/rtl/hsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared constants for the heap segment allocator: defaults, codes and
// stream word widths.
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_HEAP_BYTES   = 65536;
    localparam int DEF_HEADER_BYTES = 24;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_W       = 2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_NEXT  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

endpackage

// ----- hw/rtl/hsa_ram.sv -----
// ----------------------------------------------------------------------------
// hsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/heap_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// heap_segment_allocator
// Bounded heap allocator over an address-ordered segment table with
// first, best, worst and next fit search, splitting and coalescing on free.
// ----------------------------------------------------------------------------
// The segment table sits in one RAM with a single read and a single write
// port, and a small sequencer walks it one entry at a time (address, then
// registered data). An allocate searches the live segments and, when a
// segment is split, moves the entries above it up by one; a free searches
// for the block and then makes a coalescing pass over the table.
// s_axis_tready is high only while the sequencer is idle; a result waits
// in the output register while the next transfer is taken.
module heap_segment_allocator
    #(
    parameter int MAX_SEGMENTS = hsa_pkg::DEF_MAX_SEGMENTS,
    parameter int HEAP_BYTES   = hsa_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = hsa_pkg::DEF_HEADER_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hsa_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // request_size [16:0], block_addr [32:17]
    input  logic [hsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // action
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status [1:0], data_addr [17:2], granted_size [34:18], reused [35],
    // split_done [36], merges [42:37]
    output logic [hsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import hsa_pkg::*;

    localparam int AW  = $clog2(HEAP_BYTES + 1);
    localparam int SW  = ((AW > 18) ? AW : 18) + 1;
    localparam int IW  = $clog2(MAX_SEGMENTS);
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int EW  = 2 * AW + 1;

    localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] HEAP  = SW'(HEAP_BYTES);
    localparam logic [SW-1:0] FOUR  = SW'(4);
    localparam logic [SW-1:0] THREE = SW'(3);
    localparam logic [CW-1:0] C_ONE = CW'(1);
    localparam logic [CW-1:0] C_MAX = CW'(MAX_SEGMENTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_RD   = 4'd1;
    localparam logic [3:0] S_A_CHK  = 4'd2;
    localparam logic [3:0] S_A_DEC  = 4'd3;
    localparam logic [3:0] S_SH_RD  = 4'd4;
    localparam logic [3:0] S_SH_WR  = 4'd5;
    localparam logic [3:0] S_SPL1   = 4'd6;
    localparam logic [3:0] S_SPL0   = 4'd7;
    localparam logic [3:0] S_F_RD   = 4'd8;
    localparam logic [3:0] S_F_CHK  = 4'd9;
    localparam logic [3:0] S_M0_RD  = 4'd10;
    localparam logic [3:0] S_M0_LD  = 4'd11;
    localparam logic [3:0] S_M_RD   = 4'd12;
    localparam logic [3:0] S_M_CHK  = 4'd13;
    localparam logic [3:0] S_M_END  = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_policy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_top, n_top;
    logic [IW-1:0] r_ci, n_ci;
    logic          r_cv, n_cv;
    logic [SW-1:0] r_need, n_need;
    logic [15:0]   r_addr, n_addr;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_k, n_k;
    logic          r_found, n_found;
    logic [IW-1:0] r_pick, n_pick;
    logic [AW-1:0] r_pofs, n_pofs;
    logic [AW-1:0] r_psize, n_psize;
    logic [IW-1:0] r_w, n_w;
    logic [IW-1:0] r_c0, n_c0;
    logic [AW-1:0] r_cofs, n_cofs;
    logic [AW-1:0] r_csize, n_csize;
    logic          r_cfree, n_cfree;
    logic [1:0]    r_rs, n_rs;
    logic [15:0]   r_ra, n_ra;
    logic [16:0]   r_rg, n_rg;
    logic          r_rr, n_rr;
    logic          r_rp, n_rp;
    logic [5:0]    r_rm, n_rm;
    logic          r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [AW-1:0] e_ofs, e_size;
    logic          e_free, e_fit, e_hit, m_free;
    logic [SW-1:0] e_dat, p_dat, new_top, sum_sz, rem_sz, req_ext;
    logic [IW-1:0] idx_inc;
    logic          take;

    assign e_ofs  = ram_rdata[AW-1:0];
    assign e_size = ram_rdata[2*AW-1:AW];
    assign e_free = ram_rdata[2*AW];
    assign e_fit  = e_free && (SW'(e_size) >= r_need);
    assign e_dat  = SW'(e_ofs) + HDR;
    assign e_hit  = (e_dat == SW'(r_addr));
    assign p_dat  = SW'(r_pofs) + HDR;
    assign new_top = SW'(r_top) + HDR + r_need;
    assign sum_sz = SW'(r_csize) + HDR + SW'(e_size);
    assign rem_sz = SW'(r_psize) - r_need - HDR;
    assign req_ext = SW'(s_axis_tdata[16:0]);
    assign m_free = e_free || (r_k[IW-1:0] == r_pick);
    assign idx_inc = ((CW'(r_idx) + C_ONE) == r_cnt) ? '0 : r_idx + 1'b1;

    always_comb begin
        unique case (r_policy)
            POL_BEST:  take = !r_found || (e_size < r_psize);
            POL_WORST: take = !r_found || (e_size > r_psize);
            default:   take = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;    n_top = r_top;
        n_ci = r_ci;        n_cv = r_cv;      n_need = r_need;
        n_addr = r_addr;    n_idx = r_idx;    n_k = r_k;
        n_found = r_found;  n_pick = r_pick;  n_pofs = r_pofs;
        n_psize = r_psize;  n_w = r_w;        n_c0 = r_c0;
        n_cofs = r_cofs;    n_csize = r_csize; n_cfree = r_cfree;
        n_rs = r_rs;        n_ra = r_ra;      n_rg = r_rg;
        n_rr = r_rr;        n_rp = r_rp;      n_rm = r_rm;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata = r_odata;
        ram_we = 1'b0;
        ram_waddr = r_pick;
        ram_wdata = {1'b0, r_psize, r_pofs};
        ram_raddr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                n_rs = ST_OK; n_ra = '0; n_rg = '0; n_rr = 1'b0; n_rp = 1'b0; n_rm = '0;
                n_k = '0;
                n_found = 1'b0;
                n_addr = s_axis_tdata[32:17];
                n_need = ((req_ext + THREE) >> 2) << 2;
                n_idx = (r_policy == POL_NEXT && r_cv && (CW'(r_ci) < r_cnt)) ? r_ci : '0;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == ACT_ALLOC) begin
                        if (s_axis_tdata[16:0] == '0) begin
                            n_rs = ST_ZERO;
                            n_state = S_DONE;
                        end else if (r_cnt == '0) begin
                            n_state = S_A_DEC;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else begin
                        if (s_axis_tdata[32:17] == '0) begin
                            n_state = S_DONE;
                        end else if (r_cnt == '0) begin
                            n_rs = ST_BADFREE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                ram_raddr = r_idx;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                n_k = r_k + C_ONE;
                n_idx = idx_inc;
                n_state = ((r_k + C_ONE) == r_cnt) ? S_A_DEC : S_A_RD;
                if (e_fit && take) begin
                    n_found = 1'b1;
                    n_pick = r_idx;
                    n_pofs = e_ofs;
                    n_psize = e_size;
                    if (r_policy == POL_FIRST || r_policy == POL_NEXT) begin
                        n_state = S_A_DEC;
                    end
                end
            end
            S_A_DEC: begin
                if (r_found) begin
                    if (SW'(r_psize) >= r_need + HDR + FOUR && r_cnt < C_MAX) begin
                        n_k = r_cnt;
                        n_state = (r_cnt > CW'(r_pick) + C_ONE) ? S_SH_RD : S_SPL1;
                    end else begin
                        ram_we = 1'b1;
                        n_ci = r_pick;
                        n_cv = 1'b1;
                        n_ra = p_dat[15:0];
                        n_rg = r_need[16:0];
                        n_rr = 1'b1;
                        n_state = S_DONE;
                    end
                end else if (r_cnt >= C_MAX || new_top > HEAP) begin
                    n_rs = ST_NOMEM;
                    n_state = S_DONE;
                end else begin
                    ram_we = 1'b1;
                    ram_waddr = r_cnt[IW-1:0];
                    ram_wdata = {1'b0, r_need[AW-1:0], r_top};
                    n_cnt = r_cnt + C_ONE;
                    n_top = new_top[AW-1:0];
                    n_ci = r_cnt[IW-1:0];
                    n_cv = 1'b1;
                    n_ra = 16'(SW'(r_top) + HDR);
                    n_rg = r_need[16:0];
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                ram_raddr = r_k[IW-1:0] - 1'b1;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                ram_we = 1'b1;
                ram_waddr = r_k[IW-1:0];
                ram_wdata = ram_rdata;
                n_k = r_k - C_ONE;
                n_state = ((r_k - C_ONE) > CW'(r_pick) + C_ONE) ? S_SH_RD : S_SPL1;
            end
            S_SPL1: begin
                ram_we = 1'b1;
                ram_waddr = r_pick + 1'b1;
                ram_wdata = {1'b1, rem_sz[AW-1:0], AW'(p_dat + r_need)};
                n_state = S_SPL0;
            end
            S_SPL0: begin
                ram_we = 1'b1;
                ram_wdata = {1'b0, r_need[AW-1:0], r_pofs};
                n_cnt = r_cnt + C_ONE;
                n_ci = r_pick;
                n_cv = 1'b1;
                n_ra = p_dat[15:0];
                n_rg = r_need[16:0];
                n_rr = 1'b1;
                n_rp = 1'b1;
                n_state = S_DONE;
            end
            S_F_RD: begin
                ram_raddr = r_k[IW-1:0];
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (e_hit) begin
                    if (e_free) begin
                        n_rs = ST_BADFREE;
                        n_state = S_DONE;
                    end else begin
                        n_pick = r_k[IW-1:0];
                        n_rg = 17'(SW'(e_size));
                        n_state = S_M0_RD;
                    end
                end else begin
                    n_k = r_k + C_ONE;
                    if ((r_k + C_ONE) == r_cnt) begin
                        n_rs = ST_BADFREE;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_F_RD;
                    end
                end
            end
            S_M0_RD: begin
                ram_raddr = '0;
                n_k = '0;
                n_state = S_M0_LD;
            end
            S_M0_LD: begin
                n_cofs = e_ofs;
                n_csize = e_size;
                n_cfree = m_free;
                n_w = '0;
                n_c0 = r_ci;
                n_k = C_ONE;
                n_state = (r_cnt == C_ONE) ? S_M_END : S_M_RD;
            end
            S_M_RD: begin
                ram_raddr = r_k[IW-1:0];
                n_state = S_M_CHK;
            end
            S_M_CHK: begin
                if (r_cfree && m_free) begin
                    n_csize = sum_sz[AW-1:0];
                    n_rm = r_rm + 1'b1;
                    if (r_cv && (r_k[IW-1:0] <= r_c0)) begin
                        n_ci = r_ci - 1'b1;
                    end
                end else begin
                    ram_we = 1'b1;
                    ram_waddr = r_w;
                    ram_wdata = {r_cfree, r_csize, r_cofs};
                    n_w = r_w + 1'b1;
                    n_cofs = e_ofs;
                    n_csize = e_size;
                    n_cfree = m_free;
                end
                n_k = r_k + C_ONE;
                n_state = ((r_k + C_ONE) == r_cnt) ? S_M_END : S_M_RD;
            end
            S_M_END: begin
                ram_we = 1'b1;
                ram_waddr = r_w;
                ram_wdata = {r_cfree, r_csize, r_cofs};
                n_cnt = CW'(r_w) + C_ONE;
                n_ra = r_addr;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata = {5'b0, r_rm, r_rp, r_rr, r_rg, r_ra, r_rs};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= POL_FIRST;
            r_cnt    <= '0;
            r_top    <= '0;
            r_ci     <= '0;
            r_cv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_top    <= n_top;
            r_ci     <= n_ci;
            r_cv     <= n_cv;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                r_policy <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need  <= n_need;  r_addr  <= n_addr;  r_idx   <= n_idx;
        r_k     <= n_k;     r_found <= n_found; r_pick  <= n_pick;
        r_pofs  <= n_pofs;  r_psize <= n_psize; r_w     <= n_w;
        r_c0    <= n_c0;    r_cofs  <= n_cofs;  r_csize <= n_csize;
        r_cfree <= n_cfree; r_rs    <= n_rs;    r_ra    <= n_ra;
        r_rg    <= n_rg;    r_rr    <= n_rr;    r_rp    <= n_rp;
        r_rm    <= n_rm;    r_odata <= n_odata;
    end

    hsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the heap segment allocator. A behavioural copy of the
// segment table predicts each result; results are checked against it as
// they leave the block, under random idling on both sides and every policy.
// ----------------------------------------------------------------------------
module tb_top;

    import hsa_pkg::*;

    localparam int NSEG   = DEF_MAX_SEGMENTS;
    localparam int HBYTES = DEF_HEAP_BYTES;
    localparam int HDR    = DEF_HEADER_BYTES;

    typedef struct packed {
        logic [5:0]  merges;
        logic        split_done;
        logic        reused;
        logic [16:0] granted_size;
        logic [15:0] data_addr;
        logic [1:0]  status;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    heap_segment_allocator DUT (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    int unsigned   tbl_off [NSEG];
    int unsigned   tbl_size [NSEG];
    bit            tbl_free [NSEG];
    int unsigned   tbl_count;
    int unsigned   top_of_heap;
    int unsigned   cur_idx;
    bit            cur_valid;
    logic [1:0]    policy;

    t_alloc_result pending_results[$];
    int            fail_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    function automatic int unsigned find_fit(int unsigned need);
        int unsigned pick;
        int unsigned s;
        int unsigned i;
        pick = tbl_count;
        if (policy == POL_NEXT) begin
            if (tbl_count == 0) return 0;
            s = (cur_valid && cur_idx < tbl_count) ? cur_idx : 0;
            for (int k = 0; k < tbl_count; k++) begin
                i = s + k;
                if (i >= tbl_count) i -= tbl_count;
                if (tbl_free[i] && tbl_size[i] >= need) return i;
            end
            return tbl_count;
        end
        for (i = 0; i < tbl_count; i++) begin
            if (!(tbl_free[i] && tbl_size[i] >= need)) continue;
            if (policy == POL_FIRST) return i;
            if (pick == tbl_count || (policy == POL_BEST && tbl_size[i] < tbl_size[pick])
                    || (policy == POL_WORST && tbl_size[i] > tbl_size[pick]))
                pick = i;
        end
        return pick;
    endfunction

    function automatic t_alloc_result predict_alloc(int unsigned req);
        t_alloc_result r;
        int unsigned need;
        int unsigned i;
        r = '0;
        if (req == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        need = ((req + 3) >> 2) << 2;
        i = find_fit(need);
        if (i < tbl_count) begin
            if (tbl_size[i] >= need + HDR + 4 && tbl_count < NSEG) begin
                for (int j = tbl_count; j > i + 1; j--) begin
                    tbl_off[j] = tbl_off[j-1];
                    tbl_size[j] = tbl_size[j-1];
                    tbl_free[j] = tbl_free[j-1];
                end
                tbl_off[i+1] = tbl_off[i] + HDR + need;
                tbl_size[i+1] = tbl_size[i] - need - HDR;
                tbl_free[i+1] = 1'b1;
                tbl_size[i] = need;
                tbl_count++;
                r.split_done = 1'b1;
            end
            tbl_free[i] = 1'b0;
            cur_idx = i;
            cur_valid = 1'b1;
            r.status = ST_OK;
            r.data_addr = 16'(tbl_off[i] + HDR);
            r.granted_size = 17'(need);
            r.reused = 1'b1;
            return r;
        end
        if (tbl_count >= NSEG || top_of_heap + HDR + need > HBYTES) begin
            r.status = ST_NOMEM;
            return r;
        end
        i = tbl_count;
        tbl_off[i] = top_of_heap;
        tbl_size[i] = need;
        tbl_free[i] = 1'b0;
        tbl_count++;
        top_of_heap += HDR + need;
        cur_idx = i;
        cur_valid = 1'b1;
        r.data_addr = 16'(tbl_off[i] + HDR);
        r.granted_size = 17'(need);
        return r;
    endfunction

    function automatic t_alloc_result predict_free(int unsigned addr);
        t_alloc_result r;
        int unsigned i;
        int unsigned j;
        int unsigned n;
        r = '0;
        if (addr == 0) return r;
        for (i = 0; i < tbl_count; i++)
            if (tbl_off[i] + HDR == addr) break;
        if (i >= tbl_count || tbl_free[i]) begin
            r.status = ST_BADFREE;
            return r;
        end
        tbl_free[i] = 1'b1;
        r.granted_size = 17'(tbl_size[i]);
        r.data_addr = 16'(addr);
        n = 0;
        j = 0;
        while (j + 1 < tbl_count) begin
            if (tbl_free[j] && tbl_free[j+1]) begin
                tbl_size[j] += HDR + tbl_size[j+1];
                for (int k = j + 1; k + 1 < tbl_count; k++) begin
                    tbl_off[k] = tbl_off[k+1];
                    tbl_size[k] = tbl_size[k+1];
                    tbl_free[k] = tbl_free[k+1];
                end
                tbl_count--;
                if (cur_valid && cur_idx >= j + 1 && cur_idx > 0) cur_idx--;
                n++;
            end else begin
                j++;
            end
        end
        r.merges = 6'(n);
        return r;
    endfunction

    task automatic send_request(logic act, int unsigned req, int unsigned addr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {7'b0, addr[15:0], req[16:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act == ACT_ALLOC) pending_results.push_back(predict_alloc(req));
        else pending_results.push_back(predict_free(addr));
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic set_policy(logic [1:0] p);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        policy = p;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // pick a block address from the table, sometimes a bogus one
    function automatic int unsigned pick_free_addr();
        int unsigned k;
        if (tbl_count == 0 || $urandom_range(9) == 0)
            return $urandom_range(9) == 0 ? 0 : $urandom_range(65535);
        k = $urandom_range(tbl_count - 1);
        return tbl_off[k] + HDR;
    endfunction

    task automatic test_directed();
        send_request(ACT_ALLOC, 0, 0);
        send_request(ACT_FREE, 0, 0);
        send_request(ACT_FREE, 0, 16'hFFFF);
        send_request(ACT_ALLOC, 1, 16'hFFFF);
        send_request(ACT_ALLOC, 100, 0);
        send_request(ACT_ALLOC, 7, 0);
        send_request(ACT_FREE, 0, HDR);
        send_request(ACT_FREE, 0, HDR);
        send_request(ACT_ALLOC, 4, 0);
        send_request(ACT_ALLOC, 65536, 0);
        send_request(ACT_ALLOC, 17'h1FFFF, 0);
        send_request(ACT_FREE, 17'h1FFFF, pick_free_addr());
        send_request(ACT_FREE, 0, pick_free_addr());
        send_request(ACT_ALLOC, 60000, 0);
        send_request(ACT_ALLOC, 8000, 0);
    endtask

    task automatic test_random(int n);
        int unsigned sz;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 55) begin
                case ($urandom_range(9))
                    0: sz = $urandom_range(131071);
                    1: sz = $urandom_range(8192);
                    default: sz = $urandom_range(300);
                endcase
                send_request(ACT_ALLOC, sz, $urandom_range(65535));
            end else begin
                send_request(ACT_FREE, $urandom_range(131071), pick_free_addr());
            end
        end
    endtask

    task automatic test_policies(int per_phase);
        for (int p = 0; p < 4; p++) begin
            set_policy(p[1:0]);
            test_random(per_phase);
        end
    endtask

    // fill the table past its size with tiny blocks, then free picked blocks
    task automatic test_table_full();
        for (int i = 0; i < 70; i++) send_request(ACT_ALLOC, 4, 0);
        for (int i = 0; i < 50; i++)
            send_request(ACT_FREE, 0, pick_free_addr());
        send_request(ACT_ALLOC, 12, 0);
    endtask

    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[42:0];
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result, expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected st=%0d addr=%h sz=%0d reu=%0d spl=%0d mrg=%0d",
                             $time, want.status, want.data_addr, want.granted_size,
                             want.reused, want.split_done, want.merges);
                    $display("%0t           actual st=%0d addr=%h sz=%0d reu=%0d spl=%0d mrg=%0d",
                             $time, got.status, got.data_addr, got.granted_size,
                             got.reused, got.split_done, got.merges);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    initial begin
        tbl_count = 0;
        top_of_heap = 0;
        cur_idx = 0;
        cur_valid = 1'b0;
        policy = POL_FIRST;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 61;
        test_directed();
        test_policies(60);
        send_idle_pct = 61;
        recv_idle_pct = 38;
        test_table_full();
        test_policies(60);
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_policies(64);
        set_policy(POL_NEXT);
        test_table_full();
        set_policy(POL_BEST);
        test_random(60);
        drain_results();
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/hsa_pkg.sv
hw/rtl/hsa_ram.sv
hw/rtl/heap_segment_allocator.sv
verif/tb_top.sv
